// ===== rtl/lct_pkg.sv =====
// lct_pkg: shared types and constants for the LFU cache table unit.
// Used by lct_ctrl, lct_datapath, lct_checker and the top level; no dependencies.
`default_nettype none

package lct_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CNT_W       = 16;
	localparam int STAMP_W     = 32;
	localparam int CAP_W       = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	typedef enum logic [0:0] {
		MODE_GET = 1'b0,
		MODE_PUT = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic load_req;
		logic issue;
		logic commit;
		logic deliver;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/lct_ctrl.sv =====
// lct_ctrl: request sequencer for the LFU cache table unit.
// Depends on lct_pkg (state_t, cmd_t, status_t).
`default_nettype none

module lct_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  lct_pkg::status_t     status,
	output lct_pkg::cmd_t        cmd
);

	lct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lct_pkg::ST_IDLE: begin
				if (in_valid) state_d = lct_pkg::ST_SCAN;
			end
			lct_pkg::ST_SCAN: begin
				if (status.scan_last) state_d = lct_pkg::ST_DRAIN;
			end
			lct_pkg::ST_DRAIN: begin
				state_d = lct_pkg::ST_COMMIT;
			end
			lct_pkg::ST_COMMIT: begin
				state_d = lct_pkg::ST_DELIVER;
			end
			lct_pkg::ST_DELIVER: begin
				if (status.out_free) state_d = lct_pkg::ST_IDLE;
			end
			default: begin
				state_d = lct_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lct_pkg::ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.load_req = in_valid;
			end
			lct_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			lct_pkg::ST_DRAIN: begin
			end
			lct_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			lct_pkg::ST_DELIVER: begin
				cmd.deliver = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/lct_datapath.sv =====
// lct_datapath: entry memories, scan compare, victim search, write-back and output register.
// Depends on lct_pkg; driven by lct_ctrl through cmd_t / status_t.
`default_nettype none

module lct_datapath #(
	parameter int ENTRIES = lct_pkg::ENTRIES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire        [lct_pkg::CAP_W-1:0]      cfg_data,
	input  wire                                  mode,
	input  wire        [lct_pkg::KEY_W-1:0]      key,
	input  wire signed [lct_pkg::VAL_W-1:0]      value,
	input  wire                                  out_stall,
	output logic                                 out_valid,
	output logic                                 hit,
	output logic signed [lct_pkg::VAL_W-1:0]     read_value,
	input  lct_pkg::cmd_t                        cmd,
	output lct_pkg::status_t                     status
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > lct_pkg::CAP_W) ? OCC_W : lct_pkg::CAP_W;

	logic        [lct_pkg::KEY_W-1:0]   mem_key   [ENTRIES];
	logic signed [lct_pkg::VAL_W-1:0]   mem_value [ENTRIES];
	logic        [lct_pkg::CNT_W-1:0]   mem_cnt   [ENTRIES];
	logic        [lct_pkg::STAMP_W-1:0] mem_stamp [ENTRIES];

	logic [ENTRIES-1:0]            valid_q;
	logic [OCC_W-1:0]              occ_q;
	logic [lct_pkg::STAMP_W-1:0]   clock_q;
	logic [lct_pkg::CAP_W-1:0]     cap_q;

	logic                          mode_q;
	logic [lct_pkg::KEY_W-1:0]     key_q;
	logic signed [lct_pkg::VAL_W-1:0] value_q;

	logic [IDX_W-1:0]              scan_q;
	logic                          pipe_v_s1;
	logic                          vld_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic [lct_pkg::KEY_W-1:0]     rd_key_s1;
	logic signed [lct_pkg::VAL_W-1:0] rd_value_s1;
	logic [lct_pkg::CNT_W-1:0]     rd_cnt_s1;
	logic [lct_pkg::STAMP_W-1:0]   rd_stamp_s1;

	logic                          hit_q;
	logic [IDX_W-1:0]              slot_q;
	logic signed [lct_pkg::VAL_W-1:0] hit_val_q;
	logic [lct_pkg::CNT_W-1:0]     hit_cnt_q;
	logic                          free_q;
	logic [IDX_W-1:0]              free_slot_q;
	logic                          vic_q;
	logic [IDX_W-1:0]              vic_slot_q;
	logic [lct_pkg::CNT_W-1:0]     vic_cnt_q;
	logic [lct_pkg::STAMP_W-1:0]   vic_stamp_q;

	logic                          res_hit_q;
	logic signed [lct_pkg::VAL_W-1:0] res_val_q;
	logic                          out_valid_q;
	logic                          out_hit_q;
	logic signed [lct_pkg::VAL_W-1:0] out_val_q;

	logic [CMP_W-1:0]              cap_ext, eff_cap, occ_ext;
	logic                          full, use_victim, is_put;
	logic                          key_match, better;
	logic                          wr_en, ins_en;
	logic [IDX_W-1:0]              wr_slot;
	logic [lct_pkg::CNT_W-1:0]     wr_cnt;
	logic signed [lct_pkg::VAL_W-1:0] wr_val;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lct_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		occ_ext = CMP_W'(occ_q);
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		full       = (occ_ext >= eff_cap);
		use_victim = full || !free_q;
		is_put     = (mode_q == lct_pkg::MODE_PUT);

		key_match = vld_s1 && (rd_key_s1 == key_q);
		better    = !vic_q || (rd_cnt_s1 < vic_cnt_q) ||
			((rd_cnt_s1 == vic_cnt_q) && (rd_stamp_s1 < vic_stamp_q));

		wr_en   = cmd.commit && (hit_q || is_put);
		ins_en  = cmd.commit && !hit_q && is_put;
		wr_slot = hit_q ? slot_q : (use_victim ? vic_slot_q : free_slot_q);
		if (!hit_q) begin
			wr_cnt = lct_pkg::CNT_W'(1);
		end else if (hit_cnt_q == lct_pkg::CNT_MAX) begin
			wr_cnt = hit_cnt_q;
		end else begin
			wr_cnt = hit_cnt_q + lct_pkg::CNT_W'(1);
		end
		wr_val = is_put ? value_q : hit_val_q;
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q  <= mode;
			key_q   <= key;
			value_q <= value;
		end
	end

	// entry memories: one read port for the scan, one write port for commit
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_key[wr_slot]   <= key_q;
			mem_value[wr_slot] <= wr_val;
			mem_cnt[wr_slot]   <= wr_cnt;
			mem_stamp[wr_slot] <= clock_q;
		end
		if (cmd.issue) begin
			rd_key_s1   <= mem_key[scan_q];
			rd_value_s1 <= mem_value[scan_q];
			rd_cnt_s1   <= mem_cnt[scan_q];
			rd_stamp_s1 <= mem_stamp[scan_q];
			vld_s1      <= valid_q[scan_q];
			idx_s1      <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			pipe_v_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			vic_q     <= 1'b0;
		end else begin
			pipe_v_s1 <= cmd.issue;
			if (cmd.load_req) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				vic_q  <= 1'b0;
			end else begin
				if (cmd.issue) scan_q <= scan_q + IDX_W'(1);
				if (pipe_v_s1) begin
					if (!hit_q && key_match) hit_q <= 1'b1;
					if (!vld_s1 && !free_q) free_q <= 1'b1;
					if (vld_s1 && better) vic_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_v_s1) begin
			if (!hit_q && key_match) begin
				slot_q    <= idx_s1;
				hit_val_q <= rd_value_s1;
				hit_cnt_q <= rd_cnt_s1;
			end
			if (!vld_s1 && !free_q) free_slot_q <= idx_s1;
			if (vld_s1 && better) begin
				vic_slot_q  <= idx_s1;
				vic_cnt_q   <= rd_cnt_s1;
				vic_stamp_q <= rd_stamp_s1;
			end
		end
	end

	// occupancy, valid bits, access clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			clock_q <= '0;
		end else begin
			if (wr_en) clock_q <= clock_q + lct_pkg::STAMP_W'(1);
			if (ins_en) begin
				valid_q[wr_slot] <= 1'b1;
				if (!use_victim) occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	// result and output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_hit_q <= hit_q;
			res_val_q <= (!is_put && hit_q) ? hit_val_q : '0;
		end
		if (cmd.deliver) begin
			out_hit_q <= res_hit_q;
			out_val_q <= res_val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = out_hit_q;
	assign read_value       = out_val_q;
	assign status.scan_last = (scan_q == IDX_W'(ENTRIES - 1));
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

// ===== rtl/lfu_cache_table_unit.sv =====
// lfu_cache_table_unit: fully associative LFU key-value cache with LRU tie break.
// Depends on lct_pkg, lct_ctrl and lct_datapath.
//
//   channel   signals                       dir   accepted when
//   in        in_valid in_stall mode key value   in    in_valid && !in_stall
//   out       out_valid out_stall hit read_value out   out_valid && !out_stall
//   cfg       cfg_we cfg_data                 in    cfg_we
//
// A request is accepted in the idle state, then every entry is read once through the single
// read port of the entry memory in the scan state, followed by the drain, commit and
// deliver states; deliver waits while out_stall holds a previous result.
// One request is in flight at a time; in_stall is low only when idle.
// The next request is accepted while a result waits on out_stall.
// Reset empties the table at once; no clearing pass.
`default_nettype none

module lfu_cache_table_unit #(
	parameter int ENTRIES = lct_pkg::ENTRIES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire        [lct_pkg::CAP_W-1:0]      cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  mode,
	input  wire        [lct_pkg::KEY_W-1:0]      key,
	input  wire signed [lct_pkg::VAL_W-1:0]      value,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 hit,
	output logic signed [lct_pkg::VAL_W-1:0]     read_value
);

	lct_pkg::cmd_t    cmd;
	lct_pkg::status_t status;

	lct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lct_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.key        (key),
		.value      (value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.hit        (hit),
		.read_value (read_value),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

`default_nettype wire

// ===== rtl/lct_checker.sv =====
// lct_checker: port-level assertions for lfu_cache_table_unit, bound to the top level.
// Depends on lct_pkg for field widths.
`default_nettype none

module lct_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             in_valid,
	input wire                             in_stall,
	input wire                             out_valid,
	input wire                             out_stall,
	input wire                             hit,
	input wire signed [lct_pkg::VAL_W-1:0] read_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit) && $stable(read_value))
		else $error("stalled result changed");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in flight");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> read_value == '0)
		else $error("miss result carries nonzero value");

endmodule

bind lfu_cache_table_unit lct_checker u_lct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hit        (hit),
	.read_value (read_value)
);

`default_nettype wire
